// File: rtl/ftss_pkg.sv
// ----------------------------------------------------------------------------
// ftss_pkg: shared types and constants for the fm tone segment synthesizer
// widths, register codes, controller commands and the sine table builder
// ----------------------------------------------------------------------------
package ftss_pkg;

    localparam int CFG_W     = 31;
    localparam int STEP_W    = 31;
    localparam int AMP_W     = 15;
    localparam int INT_W     = 8;
    localparam int SAMPLE_W  = 16;
    localparam int PHASE_W   = 32;
    localparam int RES_W     = 25;
    localparam int FRAC_W    = 24;
    localparam int SIN_W     = 31;
    localparam int CFG_IDX_W = 3;

    localparam int SINE_ADDR_BITS_DEFAULT = 10;
    localparam int MAX_RUN_DEFAULT        = 64;

    // byte-serial divide by 255
    localparam int DIV_W     = 40;
    localparam int DIV_STEPS = DIV_W / 8;
    localparam int DIV_BASE  = 255;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    localparam logic [CFG_W-1:0] BLACK_STEP_RESET   = 31'd134217728;
    localparam logic [CFG_W-1:0] WHITE_STEP_RESET   = 31'd205799851;
    localparam logic [CFG_W-1:0] SYNC_STEP_RESET    = 31'd107374182;
    localparam logic [CFG_W-1:0] PIXEL_LENGTH_RESET = 31'd369360896;
    localparam logic [CFG_W-1:0] SYNC_LENGTH_RESET  = 31'd1006632960;
    localparam logic [AMP_W-1:0] AMPLITUDE_RESET    = 15'd25000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLACK_STEP,
        REG_WHITE_STEP,
        REG_SYNC_STEP,
        REG_PIXEL_LENGTH,
        REG_SYNC_LENGTH,
        REG_AMPLITUDE
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MUL_DIFF_P,
        MUL_S_T,
        MUL_S_LEN
    } mul_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DIFF,
        ST_DIVIDE,
        ST_STEP,
        ST_MUL_T,
        ST_MUL_L,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_load;
        logic     div_step;
        logic     step_load;
        logic     phase_load;
        logic     issue;
        logic     finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pipe_en;
        logic tk_lt_len;
        logic last_sample;
    } ctrl_status_t;

    // quarter-wave sine magnitude in q30, evaluated at elaboration only
    function automatic logic [SIN_W-1:0] sine_entry(input int unsigned r,
                                                     input int unsigned abits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (64'(r) * TWO_PI_Q30) >> abits;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 9; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        return sum[SIN_W-1:0];
    endfunction

endpackage

// File: rtl/ftss_if.sv
// ----------------------------------------------------------------------------
// ftss_if: request channels of the fm tone segment synthesizer
// segment requests in, audio sample requests out
// ----------------------------------------------------------------------------
interface ftss_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [ftss_pkg::INT_W-1:0]     intensity;

    modport source (output valid, output operation, output intensity, input ready);
    modport sink   (input valid, input operation, input intensity, output ready);
endinterface

interface ftss_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ftss_pkg::SAMPLE_W-1:0]  sample;
    logic                                  last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

// File: rtl/ftss_sine_pipe.sv
// ----------------------------------------------------------------------------
// ftss_sine_pipe: phase to sample pipeline
// quarter-wave table read, amplitude scaling, sign and output register
// ----------------------------------------------------------------------------
module ftss_sine_pipe #(
    parameter int SINE_ADDR_BITS = ftss_pkg::SINE_ADDR_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [ftss_pkg::AMP_W-1:0]            amplitude,
    input  logic                                  issue,
    input  logic [ftss_pkg::PHASE_W-1:0]          phase,
    input  logic                                  last_in,
    output logic                                  en,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [ftss_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  last
);
    import ftss_pkg::*;

    localparam int QSIZE = 1 << (SINE_ADDR_BITS - 2);
    localparam int R_W   = SINE_ADDR_BITS - 1;

    logic [SIN_W-1:0] sin_rom [QSIZE+1];

    for (genvar g = 0; g <= QSIZE; g++)
    begin : g_rom
        assign sin_rom[g] = sine_entry(g, SINE_ADDR_BITS);
    end

    logic [SINE_ADDR_BITS-1:0] idx;
    logic [1:0]                quad;
    logic [R_W-1:0]            r_low;
    logic [R_W-1:0]            r;
    logic [AMP_W+SIN_W-1:0]    scaled;

    logic                v1_reg, v2_reg, v3_reg;
    logic [SIN_W-1:0]    sin1_reg;
    logic                neg1_reg, neg2_reg;
    logic                last1_reg, last2_reg, last3_reg;
    logic [AMP_W-1:0]    mag2_reg;
    logic [SAMPLE_W-1:0] sample3_reg;

    assign idx   = phase[PHASE_W-1 -: SINE_ADDR_BITS];
    assign quad  = idx[SINE_ADDR_BITS-1 -: 2];
    assign r_low = {1'b0, idx[SINE_ADDR_BITS-3:0]};
    assign r     = quad[0] ? (R_W'(QSIZE) - r_low) : r_low;

    assign scaled = {{SIN_W{1'b0}}, amplitude} * {{AMP_W{1'b0}}, sin1_reg};

    assign en        = !v3_reg || out_ready;
    assign out_valid = v3_reg;
    assign sample    = signed'(sample3_reg);
    assign last      = last3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin1_reg    <= sin_rom[r];
            neg1_reg    <= quad[1];
            last1_reg   <= last_in;
            mag2_reg    <= scaled[30 +: AMP_W];
            neg2_reg    <= neg1_reg;
            last2_reg   <= last1_reg;
            sample3_reg <= neg2_reg ? (SAMPLE_W'(0) - {1'b0, mag2_reg}) : {1'b0, mag2_reg};
            last3_reg   <= last2_reg;
        end
    end

    a_issue_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> en)
        else $error("sample issued into a stalled pipeline");

endmodule

// File: rtl/ftss_ctrl.sv
// ----------------------------------------------------------------------------
// ftss_ctrl: segment sequencer
// steps each segment through setup, the sample run and the state update
// ----------------------------------------------------------------------------
module ftss_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output ftss_pkg::ctrl_cmd_t    cmd,
    input  ftss_pkg::ctrl_status_t status
);
    import ftss_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_DIFF;
                end
            end
            ST_MUL_DIFF:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_DIFF_P;
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_STEP;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_STEP:
            begin
                cmd.step_load = 1'b1;
                state_next    = ST_MUL_T;
            end
            ST_MUL_T:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_S_T;
                state_next  = ST_MUL_L;
            end
            ST_MUL_L:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_S_LEN;
                cmd.phase_load = 1'b1;
                state_next     = ST_RUN;
            end
            ST_RUN:
            begin
                if (!status.tk_lt_len)
                    state_next = ST_FINISH;
                else if (status.pipe_en)
                begin
                    cmd.issue = 1'b1;
                    if (status.last_sample)
                        state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> cnt_reg < CNT_W'(DIV_STEPS))
        else $error("divide digit count out of range");

endmodule

// File: rtl/ftss_datapath.sv
// ----------------------------------------------------------------------------
// ftss_datapath: configuration, step and timing arithmetic
// shared multiplier, byte-serial divide by 255, phase and time accumulators
// ----------------------------------------------------------------------------
module ftss_datapath #(
    parameter int SINE_ADDR_BITS = ftss_pkg::SINE_ADDR_BITS_DEFAULT,
    parameter int MAX_RUN        = ftss_pkg::MAX_RUN_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [ftss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ftss_pkg::CFG_W-1:0]            cfg_data,
    input  ftss_pkg::ctrl_cmd_t                   cmd,
    output ftss_pkg::ctrl_status_t                status,
    input  logic                                  operation,
    input  logic [ftss_pkg::INT_W-1:0]            intensity,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [ftss_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  last
);
    import ftss_pkg::*;

    localparam int LEN_W  = $clog2(MAX_RUN + 1) + FRAC_W;
    localparam int PROD_W = STEP_W + LEN_W;
    localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(MAX_RUN) << FRAC_W;
    localparam logic [LEN_W-1:0] ONE_SAMPLE = LEN_W'(1) << FRAC_W;

    // configuration
    logic [CFG_W-1:0] black_reg, white_reg, sync_step_reg;
    logic [CFG_W-1:0] pixel_len_reg, sync_dur_reg;
    logic [AMP_W-1:0] amp_reg;

    // carried state
    logic [PHASE_W-1:0] phase_base_reg;
    logic [RES_W-1:0]   residual_reg;

    // per segment
    logic                op_reg;
    logic [INT_W-1:0]    p_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    tk_reg;
    logic [STEP_W-1:0]   absdiff_reg;
    logic                neg_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DIV_W-1:0]    num_reg;
    logic [7:0]          rem_reg;
    logic [STEP_W-1:0]   quo_reg;
    logic [STEP_W-1:0]   s_reg;
    logic [PHASE_W-1:0]  ph_reg;

    logic [CFG_W-1:0]   len_sel;
    logic [LEN_W-1:0]   len_clamped;
    logic [PHASE_W-1:0] diff;
    logic [PHASE_W-1:0] diff_abs;
    logic [STEP_W-1:0]  mul_a;
    logic [LEN_W-1:0]   mul_b;
    logic [PROD_W-1:0]  product;
    logic [15:0]        dv;
    logic [8:0]         dsum;
    logic [7:0]         digit;
    logic [7:0]         rem_next;
    logic [LEN_W-1:0]   tk_next;
    logic               pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_reg     <= BLACK_STEP_RESET;
            white_reg     <= WHITE_STEP_RESET;
            sync_step_reg <= SYNC_STEP_RESET;
            pixel_len_reg <= PIXEL_LENGTH_RESET;
            sync_dur_reg  <= SYNC_LENGTH_RESET;
            amp_reg       <= AMPLITUDE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BLACK_STEP:   black_reg     <= cfg_data;
                REG_WHITE_STEP:   white_reg     <= cfg_data;
                REG_SYNC_STEP:    sync_step_reg <= cfg_data;
                REG_PIXEL_LENGTH: pixel_len_reg <= cfg_data;
                REG_SYNC_LENGTH:  sync_dur_reg  <= cfg_data;
                REG_AMPLITUDE:    amp_reg       <= cfg_data[AMP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign len_sel     = operation ? sync_dur_reg : pixel_len_reg;
    assign len_clamped = (len_sel > CFG_W'(MAX_LEN)) ? MAX_LEN : len_sel[LEN_W-1:0];
    assign diff        = {1'b0, white_reg} - {1'b0, black_reg};
    assign diff_abs    = diff[PHASE_W-1] ? (PHASE_W'(0) - diff) : diff;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DIFF_P:
            begin
                mul_a = absdiff_reg;
                mul_b = LEN_W'(p_reg);
            end
            MUL_S_T:
            begin
                mul_a = s_reg;
                mul_b = tk_reg;
            end
            MUL_S_LEN:
            begin
                mul_a = s_reg;
                mul_b = len_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = {{LEN_W{1'b0}}, mul_a} * {{STEP_W{1'b0}}, mul_b};

    // one quotient byte: v = 256q + lo = 255q + (q + lo)
    assign dv   = {rem_reg, num_reg[DIV_W-1 -: 8]};
    assign dsum = {1'b0, dv[15:8]} + {1'b0, dv[7:0]};
    always_comb
    begin
        if (dsum >= 9'(DIV_BASE))
        begin
            digit    = dv[15:8] + 8'd1;
            rem_next = 8'(dsum - 9'(DIV_BASE));
        end
        else
        begin
            digit    = dv[15:8];
            rem_next = dsum[7:0];
        end
    end

    assign tk_next            = tk_reg + ONE_SAMPLE;
    assign status.tk_lt_len   = tk_reg < len_reg;
    assign status.last_sample = !(tk_next < len_reg);
    assign status.pipe_en     = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_base_reg <= '0;
            residual_reg   <= RES_W'(ONE_SAMPLE);
        end
        else if (cmd.finish)
        begin
            phase_base_reg <= phase_base_reg + prod_reg[FRAC_W +: PHASE_W];
            residual_reg   <= RES_W'(tk_reg - len_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            p_reg       <= intensity;
            len_reg     <= len_clamped;
            absdiff_reg <= diff_abs[STEP_W-1:0];
            neg_reg     <= diff[PHASE_W-1];
        end
        if (cmd.mul_en)
            prod_reg <= product;
        if (cmd.div_load)
        begin
            num_reg <= product[DIV_W-1:0];
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= num_reg << 8;
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[STEP_W-9:0], digit};
        end
        if (cmd.step_load)
            s_reg <= op_reg ? sync_step_reg
                            : (neg_reg ? (black_reg - quo_reg) : (black_reg + quo_reg));
        if (cmd.load)
            tk_reg <= LEN_W'(residual_reg);
        else if (cmd.issue)
            tk_reg <= tk_next;
        if (cmd.phase_load)
            ph_reg <= phase_base_reg + prod_reg[FRAC_W +: PHASE_W];
        else if (cmd.issue)
            ph_reg <= ph_reg + PHASE_W'(s_reg);
    end

    ftss_sine_pipe #(
        .SINE_ADDR_BITS(SINE_ADDR_BITS)
    ) u_sine_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .amplitude (amp_reg),
        .issue     (cmd.issue),
        .phase     (ph_reg),
        .last_in   (status.last_sample),
        .en        (pipe_en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .last      (last)
    );

    a_issue_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> tk_reg < len_reg)
        else $error("sample issued past segment end");

    a_len_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> len_reg <= MAX_LEN)
        else $error("segment length above run limit");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> rem_reg < 8'(DIV_BASE))
        else $error("divide remainder out of range");

    a_residual_bound: assert property (@(posedge clk) disable iff (!rst_n)
        residual_reg <= RES_W'(ONE_SAMPLE))
        else $error("time residual above one sample period");

endmodule

// File: rtl/fm_tone_segment_synth.sv
// ----------------------------------------------------------------------------
// fm_tone_segment_synth: phase-continuous fm tone generator
// turns pixel and sync segment requests into a run of sine samples
// ----------------------------------------------------------------------------
// One segment request is taken at a time. Each goes through setup and a state
// update (a length load, the intensity product, a five-step byte-serial divide
// by 255, the start-phase and phase-advance products on one shared multiplier)
// around its run of samples, one sample per cycle while the output does not
// stall. A segment may emit no sample; at reset settings a pixel emits 22 or 23
// and a sync segment 59 or 60. Samples leave through a three-stage table, scale
// and output pipeline, and a stall on the output side holds the sample run.
module fm_tone_segment_synth #(
    parameter int SINE_ADDR_BITS = ftss_pkg::SINE_ADDR_BITS_DEFAULT,
    parameter int MAX_RUN        = ftss_pkg::MAX_RUN_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ftss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ftss_pkg::CFG_W-1:0]      cfg_data,
    ftss_in_if.sink                         segment,
    ftss_out_if.source                      result
);
    import ftss_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    ftss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (segment.valid),
        .in_ready (segment.ready),
        .cmd      (cmd),
        .status   (status)
    );

    ftss_datapath #(
        .SINE_ADDR_BITS(SINE_ADDR_BITS),
        .MAX_RUN       (MAX_RUN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .operation (segment.operation),
        .intensity (segment.intensity),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sample    (result.sample),
        .last      (result.last)
    );

endmodule

// File: sim/ftss_checker.sv
// ----------------------------------------------------------------------------
// ftss_checker: output predictor and scoreboard for the fm tone synthesizer
// watches the register port and both request channels, works out the samples
// each accepted segment must produce and compares every output request in
// order against them; the failure count and outstanding sample count go to
// the testbench top
// ----------------------------------------------------------------------------
module ftss_checker #(
    parameter int SINE_ADDR_BITS = ftss_pkg::SINE_ADDR_BITS_DEFAULT,
    parameter int MAX_RUN        = ftss_pkg::MAX_RUN_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ftss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ftss_pkg::CFG_W-1:0]     cfg_data,
    ftss_in_if                             segment,
    ftss_out_if                            result,
    output int                             fail_count,
    output int                             pending,
    output int                             segment_count,
    output int                             sync_count,
    output int                             silent_count,
    output int                             sample_count
);
    import ftss_pkg::*;

    localparam int              QUARTER     = 1 << (SINE_ADDR_BITS - 2);
    localparam longint unsigned CIRCLE_Q30  = 64'd6746518852;
    localparam longint unsigned SINE_ONE    = 64'd1 << 30;
    localparam longint unsigned ONE_SAMPLE  = 64'd1 << FRAC_W;
    localparam longint unsigned RUN_CAP     = longint'(MAX_RUN) * ONE_SAMPLE;
    localparam int              REPORT_MAX  = 20;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } tone_sample_t;

    logic [CFG_W-1:0]   cfg_black;
    logic [CFG_W-1:0]   cfg_white;
    logic [CFG_W-1:0]   cfg_sync;
    logic [CFG_W-1:0]   cfg_pixel_len;
    logic [CFG_W-1:0]   cfg_sync_dur;
    logic [AMP_W-1:0]   cfg_amp;
    logic [PHASE_W-1:0] phase_acc;
    logic [RES_W-1:0]   first_instant;

    longint unsigned    quarter_sine [0:QUARTER];
    tone_sample_t       tone_samples_due [$];
    tone_sample_t       want;
    int                 reported;
    int                 produced;

    function automatic longint unsigned sine_q30(input int unsigned r);
        longint unsigned x;
        longint unsigned term;
        longint unsigned denom;
        longint          acc;
        int              k;
        x    = r;
        x    = (x * CIRCLE_Q30) >> SINE_ADDR_BITS;
        term = x;
        acc  = longint'(x);
        for (k = 1; k <= 9; k++)
        begin
            term  = (term * x) >> 30;
            term  = (term * x) >> 30;
            denom = (2 * k) * (2 * k + 1);
            term  = term / denom;
            if ((k % 2) == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > longint'(SINE_ONE))
            acc = longint'(SINE_ONE);
        return longint'(acc);
    endfunction

    initial
    begin
        for (int r = 0; r <= QUARTER; r++)
            quarter_sine[r] = sine_q30(r);
    end

    // amplitude * sin(phase), truncated toward zero, from the quarter wave
    function automatic logic [SAMPLE_W-1:0] tone_level(input logic [PHASE_W-1:0] ph);
        int unsigned     idx;
        int unsigned     quad;
        int unsigned     r;
        longint unsigned scale;
        longint unsigned mag;
        idx  = ph >> (PHASE_W - SINE_ADDR_BITS);
        quad = idx >> (SINE_ADDR_BITS - 2);
        r    = idx & (QUARTER - 1);
        if (quad[0])
            r = QUARTER - r;
        scale = cfg_amp;
        mag   = (scale * quarter_sine[r]) >> 30;
        if (quad[1])
            return SAMPLE_W'(64'd0 - mag);
        else
            return SAMPLE_W'(mag);
    endfunction

    // queue the samples of one segment and carry phase and timing forward
    function automatic int synth_segment(input logic op, input logic [INT_W-1:0] level);
        longint          base;
        longint          span;
        longint          lvl;
        longint unsigned step;
        longint unsigned len;
        longint unsigned tk;
        logic [PHASE_W-1:0] ph;
        tone_sample_t    item;
        int              n;
        if (op)
        begin
            step = cfg_sync;
            len  = cfg_sync_dur;
        end
        else
        begin
            base = cfg_black;
            span = cfg_white;
            span = span - base;
            lvl  = level;
            step = longint'(base + (span * lvl) / 255);
            len  = cfg_pixel_len;
        end
        if (len > RUN_CAP)
            len = RUN_CAP;
        tk = first_instant;
        n  = 0;
        while (tk < len && n < MAX_RUN)
        begin
            ph          = phase_acc + PHASE_W'((step * tk) >> FRAC_W);
            item.sample = tone_level(ph);
            item.last   = !((tk + ONE_SAMPLE < len) && (n + 1 < MAX_RUN));
            tone_samples_due.push_back(item);
            n++;
            tk = tk + ONE_SAMPLE;
        end
        first_instant = RES_W'(tk - len);
        phase_acc     = phase_acc + PHASE_W'((step * len) >> FRAC_W);
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_black     = BLACK_STEP_RESET;
            cfg_white     = WHITE_STEP_RESET;
            cfg_sync      = SYNC_STEP_RESET;
            cfg_pixel_len = PIXEL_LENGTH_RESET;
            cfg_sync_dur  = SYNC_LENGTH_RESET;
            cfg_amp       = AMPLITUDE_RESET;
            phase_acc     = '0;
            first_instant = RES_W'(ONE_SAMPLE);
            tone_samples_due.delete();
            fail_count    = 0;
            segment_count = 0;
            sync_count    = 0;
            silent_count  = 0;
            sample_count  = 0;
            reported      = 0;
            pending      <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BLACK_STEP:   cfg_black     = cfg_data;
                    REG_WHITE_STEP:   cfg_white     = cfg_data;
                    REG_SYNC_STEP:    cfg_sync      = cfg_data;
                    REG_PIXEL_LENGTH: cfg_pixel_len = cfg_data;
                    REG_SYNC_LENGTH:  cfg_sync_dur  = cfg_data;
                    REG_AMPLITUDE:    cfg_amp       = cfg_data[AMP_W-1:0];
                    default: ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                if (tone_samples_due.size() == 0)
                begin
                    fail_count++;
                    if (reported < REPORT_MAX)
                        $display("%0t: unexpected output request: %s %0d last %0b",
                                 $time, "expected none, got",
                                 $signed(result.sample), result.last);
                    reported++;
                end
                else
                begin
                    want = tone_samples_due.pop_front();
                    sample_count++;
                    if (result.sample !== want.sample || result.last !== want.last)
                    begin
                        fail_count++;
                        if (reported < REPORT_MAX)
                            $display("%0t: sample mismatch: %s %0d last %0b, %s %0d last %0b",
                                     $time, "expected", $signed(want.sample), want.last,
                                     "got", $signed(result.sample), result.last);
                        reported++;
                    end
                end
            end

            if (segment.valid && segment.ready)
            begin
                produced = synth_segment(segment.operation, segment.intensity);
                segment_count++;
                if (segment.operation)
                    sync_count++;
                if (produced == 0)
                    silent_count++;
            end

            pending <= tone_samples_due.size();
        end
    end

endmodule

// File: sim/fm_tone_segment_synth_tb.sv
// ----------------------------------------------------------------------------
// fm_tone_segment_synth_tb: testbench top for the fm tone segment synthesizer
// drives pixel and sync segment requests and register settings with random
// gaps and output stalls; a checker beside the block predicts every sample
// and this top reports the verdict
// ----------------------------------------------------------------------------
module fm_tone_segment_synth_tb;
    import ftss_pkg::*;

    localparam int     SETTLE_CYCLES = 40;
    localparam int     MAX_GAP       = 12;
    localparam int     HOLD_AFTER    = 150;
    localparam int     HOLD_CYCLES   = 300;
    localparam longint TIME_LIMIT    = 40_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_SYNC  = 1'b1;

    localparam logic [CFG_W-1:0] STEP_MAX  = 31'h7FFF_FFFF;
    localparam logic [CFG_W-1:0] LEN_MIN   = 31'h0200_0000;
    localparam logic [CFG_W-1:0] LEN_MAX   = 31'h4000_0000;
    localparam logic [CFG_W-1:0] LEN_SHORT = 31'h0080_0000;
    localparam logic [CFG_W-1:0] LEN_OVER  = 31'h7FFF_FFFF;
    localparam logic [AMP_W-1:0] AMP_MAX   = 15'h7FFF;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int segment_count;
    int sync_count;
    int silent_count;
    int sample_count;
    int settings_count = 0;
    bit sender_fast    = 1'b0;
    bit receiver_fast  = 1'b0;

    ftss_in_if  segment_ch ();
    ftss_out_if result_ch ();

    fm_tone_segment_synth dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .segment   (segment_ch),
        .result    (result_ch)
    );

    ftss_checker watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .segment       (segment_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .segment_count (segment_count),
        .sync_count    (sync_count),
        .silent_count  (silent_count),
        .sample_count  (sample_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_segment(input logic op, input logic [INT_W-1:0] level);
        int gap;
        if ($urandom_range(0, 31) == 0)
            sender_fast = !sender_fast;
        gap = sender_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            segment_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        segment_ch.valid     <= 1'b1;
        segment_ch.operation <= op;
        segment_ch.intensity <= level;
        @(posedge clk);
        while (segment_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    // stop sending and let every outstanding sample drain
    task automatic wait_idle();
        segment_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_settings(input logic [CFG_W-1:0] black,
                                    input logic [CFG_W-1:0] white,
                                    input logic [CFG_W-1:0] sync,
                                    input logic [CFG_W-1:0] pixel_len,
                                    input logic [CFG_W-1:0] sync_dur,
                                    input logic [AMP_W-1:0] amp);
        write_one(REG_BLACK_STEP, black);
        write_one(REG_WHITE_STEP, white);
        write_one(REG_SYNC_STEP, sync);
        write_one(REG_PIXEL_LENGTH, pixel_len);
        write_one(REG_SYNC_LENGTH, sync_dur);
        write_one(REG_AMPLITUDE, CFG_W'(amp));
        // unmapped index must leave everything alone
        write_one(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
        cfg_write <= 1'b0;
        settings_count++;
    endtask

    // mostly sync burst followed by a line of pixels, some stray requests
    task automatic random_traffic(input int count);
        int sent;
        int run_len;
        int pick;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                repeat (4) send_segment(OP_SYNC, INT_W'($urandom));
                run_len = $urandom_range(4, 16);
                repeat (run_len)
                begin
                    pick = $urandom_range(0, 9);
                    send_segment(OP_PIXEL, (pick == 0) ? INT_W'(0) :
                                           (pick == 1) ? {INT_W{1'b1}} : INT_W'($urandom));
                end
                sent += 4 + run_len;
            end
            else
            begin
                send_segment(($urandom_range(0, 1) == 0) ? OP_PIXEL : OP_SYNC, INT_W'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        int gap;
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                receiver_fast = !receiver_fast;
            gap = receiver_fast ? 0 : $urandom_range(0, MAX_GAP);
            // one long stall so the block backs up into its input
            if (!held && taken >= HOLD_AFTER)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (result_ch.valid !== 1'b1)
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        cfg_write            <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        segment_ch.valid     <= 1'b0;
        segment_ch.operation <= OP_PIXEL;
        segment_ch.intensity <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        send_segment(OP_PIXEL, 8'h00);
        send_segment(OP_PIXEL, 8'hFF);
        send_segment(OP_PIXEL, 8'h55);
        send_segment(OP_PIXEL, 8'hAA);
        send_segment(OP_PIXEL, 8'd128);
        repeat (4) send_segment(OP_SYNC, 8'h3C);
        wait_idle();
        random_traffic(80);
        wait_idle();

        // extremes: full step span, shortest pixel, longest sync, full scale
        program_settings('0, STEP_MAX, STEP_MAX, LEN_MIN, LEN_MAX, AMP_MAX);
        send_segment(OP_PIXEL, 8'h00);
        send_segment(OP_PIXEL, 8'hFF);
        send_segment(OP_PIXEL, 8'h0F);
        send_segment(OP_SYNC, 8'hF0);
        send_segment(OP_SYNC, 8'h00);
        random_traffic(60);
        wait_idle();

        // white below black, zero sync step
        program_settings(STEP_MAX, '0, '0, CFG_W'($urandom_range(LEN_MIN, LEN_MAX)),
                         CFG_W'($urandom_range(LEN_MIN, LEN_MAX)), 15'd20000);
        send_segment(OP_PIXEL, 8'h00);
        send_segment(OP_PIXEL, 8'hFF);
        send_segment(OP_PIXEL, 8'd100);
        send_segment(OP_SYNC, 8'h81);
        random_traffic(60);
        wait_idle();

        // sub-sample pixels that may emit nothing, sync beyond the run cap
        program_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                         LEN_SHORT, LEN_OVER, AMP_W'($urandom));
        repeat (3) send_segment(OP_PIXEL, INT_W'($urandom));
        send_segment(OP_SYNC, INT_W'($urandom));
        repeat (2) send_segment(OP_PIXEL, INT_W'($urandom));
        random_traffic(40);
        wait_idle();

        // silent output: zero steps and zero amplitude
        program_settings('0, '0, '0, CFG_W'($urandom_range(LEN_MIN, LEN_MAX)),
                         CFG_W'($urandom_range(LEN_MIN, LEN_MAX)), '0);
        random_traffic(20);
        wait_idle();

        repeat (3)
        begin
            program_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                             CFG_W'($urandom_range(LEN_MIN, LEN_MAX)),
                             CFG_W'($urandom_range(LEN_MIN, LEN_MAX)),
                             AMP_W'($urandom_range(0, AMP_MAX)));
            random_traffic(45);
            wait_idle();
        end

        $display("covered %0d segments (%0d sync, %0d with no samples), %0d samples checked",
                 segment_count, sync_count, silent_count, sample_count);
        $display("across reset values and %0d written register settings", settings_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(TIME_LIMIT);
        $display("timeout with %0d samples outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ftss_pkg.sv
rtl/ftss_if.sv
rtl/ftss_sine_pipe.sv
rtl/ftss_ctrl.sv
rtl/ftss_datapath.sv
rtl/fm_tone_segment_synth.sv
sim/ftss_checker.sv
sim/fm_tone_segment_synth_tb.sv
